// ----- sv/trot_pkg.sv -----
package trot_pkg;

    // widths of the data path
    localparam int CW     = 32;
    localparam int AF     = 30;
    localparam int AW     = 32;
    localparam int NCOMP  = 9;
    localparam int NAXIS  = 6;
    localparam int NGROUP = 3;
    localparam int ACC_W  = 2 * AW + CW + 5;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic signed [AW-1:0] axis_t;

    // operation codes
    localparam logic [2:0] OP_STRAIN_FWD = 3'd0;
    localparam logic [2:0] OP_STRAIN_BCK = 3'd1;
    localparam logic [2:0] OP_STRESS_FWD = 3'd2;
    localparam logic [2:0] OP_STRESS_BCK = 3'd3;
    localparam logic [2:0] OP_GRAD_FWD   = 3'd4;
    localparam logic [2:0] OP_GRAD_BCK   = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_ONE_X = 3'd0;
    localparam logic [2:0] REG_ONE_Y = 3'd1;
    localparam logic [2:0] REG_ONE_Z = 3'd2;
    localparam logic [2:0] REG_TWO_X = 3'd3;
    localparam logic [2:0] REG_TWO_Y = 3'd4;
    localparam logic [2:0] REG_TWO_Z = 3'd5;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    typedef struct packed {
        logic [3:0] a_idx;
        logic [3:0] b_idx;
        logic [3:0] c_idx;
        logic       dbl;
        logic       en;
    } slot_sel_t;

    localparam logic [1:0] GRID_ROW [NCOMP] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                               2'd2, 2'd2, 2'd2};
    localparam logic [1:0] GRID_COL [NCOMP] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                               2'd0, 2'd1, 2'd2};
    localparam logic [1:0] VOIGT_ROW [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] VOIGT_COL [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    // flat index of rotation entry (r, c), transposed for backward ops
    function automatic logic [3:0] m_index(input logic [1:0] r, input logic [1:0] c,
                                           input logic back);
        logic [1:0] rr;
        logic [1:0] cc;
        rr = back ? c : r;
        cc = back ? r : c;
        return 4'({2'b00, rr} * 4'd3 + {2'b00, cc});
    endfunction

    // operands of one product term of one output lane
    function automatic slot_sel_t slot_map(input logic [2:0] op, input logic [3:0] lane,
                                           input logic [3:0] slot);
        slot_sel_t  s;
        logic       back;
        logic       strain;
        logic       diag;
        logic [1:0] p;
        logic [1:0] q;
        logic [1:0] i;
        logic [1:0] j;
        logic [2:0] k;
        s      = '0;
        back   = op[0];
        strain = (op == OP_STRAIN_FWD) || (op == OP_STRAIN_BCK);
        diag   = lane < 4'd3;
        p = '0; q = '0; i = '0; j = '0; k = '0;
        if ((op == OP_GRAD_FWD) || (op == OP_GRAD_BCK))
        begin
            p = GRID_ROW[lane];
            q = GRID_COL[lane];
            i = GRID_ROW[slot];
            j = GRID_COL[slot];
            s.a_idx = m_index(p, i, back);
            s.b_idx = m_index(q, j, back);
            s.c_idx = slot;
            s.en    = 1'b1;
        end
        else if ((op <= OP_STRESS_BCK) && (lane < 4'd6))
        begin
            p = VOIGT_ROW[lane[2:0]];
            q = VOIGT_COL[lane[2:0]];
            if (slot < 4'd3)
            begin
                // normal components
                i = slot[1:0];
                s.a_idx = m_index(p, i, back);
                s.b_idx = m_index(q, i, back);
                s.c_idx = slot;
                s.dbl   = strain && !diag;
                s.en    = 1'b1;
            end
            else if (slot < 4'd6)
            begin
                // shear components, first ordering
                k = slot[2:0];
                i = VOIGT_ROW[k];
                j = VOIGT_COL[k];
                s.a_idx = m_index(p, i, back);
                s.b_idx = m_index(q, j, back);
                s.c_idx = slot;
                s.en    = 1'b1;
            end
            else
            begin
                // shear components, swapped ordering
                k = 3'(slot - 4'd3);
                i = VOIGT_ROW[k];
                j = VOIGT_COL[k];
                s.a_idx = m_index(p, j, back);
                s.b_idx = m_index(q, i, back);
                s.c_idx = {1'b0, k};
                s.en    = !(strain && diag);
            end
        end
        return s;
    endfunction

endpackage

// ----- sv/trot_cross.sv -----
module trot_cross
    import trot_pkg::*;
(
    input  logic  clk,
    input  axis_t axis [NAXIS],
    output axis_t third [3]
);

    logic signed [2*AW-1:0] prod_reg [6];
    axis_t                  third_reg [3];
    axis_t                  third_next [3];

    // cross product partial products
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= axis[REG_ONE_Y] * axis[REG_TWO_Z];
        prod_reg[1] <= axis[REG_TWO_Y] * axis[REG_ONE_Z];
        prod_reg[2] <= axis[REG_ONE_Z] * axis[REG_TWO_X];
        prod_reg[3] <= axis[REG_TWO_Z] * axis[REG_ONE_X];
        prod_reg[4] <= axis[REG_ONE_X] * axis[REG_TWO_Y];
        prod_reg[5] <= axis[REG_TWO_X] * axis[REG_ONE_Y];
    end

    // difference, round half up, saturate
    always_comb
    begin
        logic signed [2*AW+1:0] diff;
        logic signed [2*AW+1:0] sh;
        for (int e = 0; e < 3; e++)
        begin
            diff = (2*AW+2)'(prod_reg[2*e]) - (2*AW+2)'(prod_reg[2*e+1])
                 + ((2*AW+2)'(1) <<< (AF - 1));
            sh = diff >>> AF;
            if ((&sh[2*AW+1:AW-1]) || !(|sh[2*AW+1:AW-1]))
                third_next[e] = sh[AW-1:0];
            else if (sh[2*AW+1])
                third_next[e] = {1'b1, {(AW-1){1'b0}}};
            else
                third_next[e] = {1'b0, {(AW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        third_reg <= third_next;
    end

    assign third = third_reg;

endmodule

// ----- sv/trot_lane.sv -----
module trot_lane
    import trot_pkg::*;
(
    input  logic       clk,
    input  stage_en_t  en,
    input  logic [3:0] lane,
    input  logic [2:0] op,
    input  comp_t      comp [NCOMP],
    input  axis_t      m [NCOMP],
    output comp_t      res
);

    logic signed [2*AW-1:0]  pp_reg   [NCOMP];
    comp_t                   cc_reg   [NCOMP];
    logic                    dbl2_reg [NCOMP];
    logic signed [AW+CW-1:0] phi_reg  [NCOMP];
    logic signed [AW+CW:0]   plo_reg  [NCOMP];
    logic                    dbl3_reg [NCOMP];
    logic signed [ACC_W-1:0] term     [NCOMP];
    logic signed [ACC_W-1:0] grp_reg  [NGROUP];

    for (genvar s = 0; s < NCOMP; s++)
    begin : g_slot
        slot_sel_t sel;
        assign sel = slot_map(op, lane, 4'(s));

        // rotation entry pair product and component select
        always_ff @(posedge clk)
        begin
            if (en.s2)
            begin
                pp_reg[s]   <= m[sel.a_idx] * m[sel.b_idx];
                cc_reg[s]   <= sel.en ? comp[sel.c_idx] : '0;
                dbl2_reg[s] <= sel.dbl;
            end
        end

        // split the pair product into two halves times the component
        always_ff @(posedge clk)
        begin
            if (en.s3)
            begin
                phi_reg[s]  <= $signed(pp_reg[s][2*AW-1:AW]) * cc_reg[s];
                plo_reg[s]  <= $signed({1'b0, pp_reg[s][AW-1:0]}) * cc_reg[s];
                dbl3_reg[s] <= dbl2_reg[s];
            end
        end

        // recombine halves, double engineering shear terms
        always_comb
        begin
            logic signed [ACC_W-1:0] t;
            t = (ACC_W'(phi_reg[s]) <<< AW) + ACC_W'(plo_reg[s]);
            term[s] = dbl3_reg[s] ? (t <<< 1) : t;
        end
    end

    // partial sums over groups of three terms
    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            for (int g = 0; g < NGROUP; g++)
                grp_reg[g] <= term[3*g] + term[3*g+1] + term[3*g+2];
        end
    end

    // final sum, round half up, saturate
    always_comb
    begin
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] sh;
        sum = grp_reg[0] + grp_reg[1] + grp_reg[2] + (ACC_W'(1) <<< (2*AF - 1));
        sh  = sum >>> (2*AF);
        if ((&sh[ACC_W-1:CW-1]) || !(|sh[ACC_W-1:CW-1]))
            res = sh[CW-1:0];
        else if (sh[ACC_W-1])
            res = {1'b1, {(CW-1){1'b0}}};
        else
            res = {1'b0, {(CW-1){1'b1}}};
    end

endmodule

// ----- sv/tensor_rotation_3d.sv -----
// Rotates one 3D tensor per item between the global frame and the material frame
// set by two configured axes (the third is their cross product). Strain and stress
// take six Voigt components, the deformation gradient nine; unused results are
// zero. A new item is accepted every cycle while the output is not held and the axes have settled;
// each item passes in turn the input item register, the entry pair product, the split component
// product and the partial sums of the nine output lanes, then the output register,
// which also takes the final rounded sum. Each lane forms its nine product terms in
// parallel. After reset and after every configuration write the input stays not ready
// while the cross product settles.
module tensor_rotation_3d
    import trot_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [AW-1:0] cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    op,
    input  comp_t         comp_0,
    input  comp_t         comp_1,
    input  comp_t         comp_2,
    input  comp_t         comp_3,
    input  comp_t         comp_4,
    input  comp_t         comp_5,
    input  comp_t         comp_6,
    input  comp_t         comp_7,
    input  comp_t         comp_8,
    output logic          out_valid,
    input  logic          out_ready,
    output comp_t         res_0,
    output comp_t         res_1,
    output comp_t         res_2,
    output comp_t         res_3,
    output comp_t         res_4,
    output comp_t         res_5,
    output comp_t         res_6,
    output comp_t         res_7,
    output comp_t         res_8
);

    axis_t      axis_reg [NAXIS];
    axis_t      third [3];
    axis_t      m [NCOMP];
    logic [1:0] settle_reg;
    logic       v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic       en1, en2, en3, en4, en5;
    stage_en_t  stage_en;
    logic [2:0] op1_reg;
    comp_t      comp1_reg [NCOMP];
    comp_t      lane_res [NCOMP];
    comp_t      res_reg [NCOMP];

    assign cfg_ready = 1'b1;

    // axis registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NAXIS; r++)
                axis_reg[r] <= '0;
            axis_reg[REG_ONE_X] <= axis_t'(1) <<< AF;
            axis_reg[REG_TWO_Y] <= axis_t'(1) <<< AF;
        end
        else if (cfg_valid && (cfg_index <= REG_TWO_Z))
        begin
            axis_reg[cfg_index] <= cfg_data;
        end
    end

    // hold off items while the cross product settles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 2'd2;
        else if (cfg_valid)
            settle_reg <= 2'd2;
        else if (settle_reg != 2'd0)
            settle_reg <= settle_reg - 2'd1;
    end

    trot_cross u_cross (
        .clk   (clk),
        .axis  (axis_reg),
        .third (third)
    );

    always_comb
    begin
        for (int r = 0; r < NAXIS; r++)
            m[r] = axis_reg[r];
        for (int e = 0; e < 3; e++)
            m[NAXIS+e] = third[e];
    end

    // stage advance: a stage moves when empty or when the next one moves
    assign en5 = !out_valid_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1 && (settle_reg == 2'd0);
    assign stage_en = '{s2: en2, s3: en3, s4: en4};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid && in_ready;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                out_valid_reg <= v4_reg;
        end
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg      <= op;
            comp1_reg[0] <= comp_0;
            comp1_reg[1] <= comp_1;
            comp1_reg[2] <= comp_2;
            comp1_reg[3] <= comp_3;
            comp1_reg[4] <= comp_4;
            comp1_reg[5] <= comp_5;
            comp1_reg[6] <= comp_6;
            comp1_reg[7] <= comp_7;
            comp1_reg[8] <= comp_8;
        end
    end

    // one lane per result component
    for (genvar l = 0; l < NCOMP; l++)
    begin : g_lane
        trot_lane u_lane (
            .clk  (clk),
            .en   (stage_en),
            .lane (4'(l)),
            .op   (op1_reg),
            .comp (comp1_reg),
            .m    (m),
            .res  (lane_res[l])
        );
    end

    // output register merges the lane results
    always_ff @(posedge clk)
    begin
        if (en5)
            res_reg <= lane_res;
    end

    assign out_valid = out_valid_reg;
    assign res_0 = res_reg[0];
    assign res_1 = res_reg[1];
    assign res_2 = res_reg[2];
    assign res_3 = res_reg[3];
    assign res_4 = res_reg[4];
    assign res_5 = res_reg[5];
    assign res_6 = res_reg[6];
    assign res_7 = res_reg[7];
    assign res_8 = res_reg[8];

endmodule

// ----- sv/trot_checker.sv -----
module trot_checker
    import trot_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  cfg_valid,
    input logic  cfg_ready,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input comp_t res_0
);

    // a stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(res_0))
        else $error("stalled result changed");

    // no item taken after a configuration write while the cross product settles
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("item taken right after configuration write");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> ##1 !in_ready)
        else $error("item taken before cross product settled");

endmodule

bind tensor_rotation_3d trot_checker u_trot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_0     (res_0)
);

// ----- tb/sv/tensor_rotation_3d_tb.sv -----
`timescale 1ns / 100ps

module tensor_rotation_3d_tb
    import trot_pkg::*;
();

    typedef logic [8:0][CW-1:0] tensor_t;
    typedef logic signed [127:0] acc_t;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int UNIT = 1 << AF;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;

    // keeps its own axis copy and the rotated tensors still owed by the block
    class rotation_scoreboard;
        axis_t   axis_reg [NAXIS];
        tensor_t owed [$];
        int      errors;
        int      vrow [6] = '{0, 1, 2, 0, 0, 1};
        int      vcol [6] = '{0, 1, 2, 1, 2, 2};

        function new();
            foreach (axis_reg[k])
            begin
                axis_reg[k] = '0;
            end
            axis_reg[REG_ONE_X] = UNIT;
            axis_reg[REG_TWO_Y] = UNIT;
            errors = 0;
        endfunction

        function void set_axis(logic [2:0] idx, logic [AW-1:0] data);
            if (idx < NAXIS)
            begin
                axis_reg[idx] = data;
            end
        endfunction

        // round half up by 2^s, then clamp to the signed width w
        function acc_t round_clamp(acc_t v, int s, int w);
            acc_t r;
            acc_t hi;
            acc_t lo;
            r  = (v + (acc_t'(1) <<< (s - 1))) >>> s;
            hi = (acc_t'(1) <<< (w - 1)) - 1;
            lo = -(acc_t'(1) <<< (w - 1));
            if (r > hi)
            begin
                r = hi;
            end
            else if (r < lo)
            begin
                r = lo;
            end
            return r;
        endfunction

        function axis_t cross_entry(axis_t a, axis_t b, axis_t c, axis_t d);
            acc_t v;
            v = acc_t'(a) * acc_t'(b) - acc_t'(c) * acc_t'(d);
            return axis_t'(round_clamp(v, AF, AW));
        endfunction

        function acc_t term(axis_t x, axis_t y, logic [CW-1:0] c);
            return acc_t'(x) * acc_t'(y) * acc_t'($signed(c));
        endfunction

        function tensor_t rotate_tensor(logic [2:0] opc, tensor_t c);
            axis_t   m [3][3];
            axis_t   g [3][3];
            tensor_t r;
            acc_t    acc;
            bit      back;
            bit      strain;
            bit      diag;
            int      p;
            int      q;
            int      i;
            int      j;
            r = '0;
            if (opc > OP_GRAD_BCK)
            begin
                return r;
            end
            back = opc[0];
            for (int k = 0; k < 3; k++)
            begin
                m[0][k] = axis_reg[k];
                m[1][k] = axis_reg[3 + k];
            end
            m[2][0] = cross_entry(m[0][1], m[1][2], m[1][1], m[0][2]);
            m[2][1] = cross_entry(m[0][2], m[1][0], m[1][2], m[0][0]);
            m[2][2] = cross_entry(m[0][0], m[1][1], m[1][0], m[0][1]);
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    g[a][b] = back ? m[b][a] : m[a][b];
                end
            end
            // deformation gradient: full 3x3 sandwich
            if (opc >= OP_GRAD_FWD)
            begin
                for (int o = 0; o < 9; o++)
                begin
                    p = o / 3;
                    q = o % 3;
                    acc = '0;
                    for (int k = 0; k < 9; k++)
                    begin
                        acc += term(g[p][k / 3], g[q][k % 3], c[k]);
                    end
                    r[o] = CW'(round_clamp(acc, 2 * AF, CW));
                end
                return r;
            end
            // strain and stress in Voigt form
            strain = opc < OP_STRESS_FWD;
            for (int o = 0; o < 6; o++)
            begin
                diag = o < 3;
                p = vrow[o];
                q = vcol[o];
                acc = '0;
                for (int k = 0; k < 6; k++)
                begin
                    i = vrow[k];
                    j = vcol[k];
                    if (k < 3)
                    begin
                        acc += term(g[p][i], g[q][i], c[k]) * ((strain && !diag) ? 2 : 1);
                    end
                    else if (strain && diag)
                    begin
                        acc += term(g[p][i], g[p][j], c[k]);
                    end
                    else
                    begin
                        acc += term(g[p][i], g[q][j], c[k]) + term(g[p][j], g[q][i], c[k]);
                    end
                end
                r[o] = CW'(round_clamp(acc, 2 * AF, CW));
            end
            return r;
        endfunction

        function void note_tensor(logic [2:0] opc, tensor_t c);
            owed.push_back(rotate_tensor(opc, c));
        endfunction

        function void check_result(tensor_t got);
            tensor_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: result with nothing owed, actual %h", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            for (int k = 0; k < 9; k++)
            begin
                if (got[k] !== want[k])
                begin
                    $display("%0t: res_%0d expected %0d actual %0d", $time, k,
                             $signed(want[k]), $signed(got[k]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [AW-1:0] cfg_data;
    logic          in_valid;
    logic          in_ready;
    logic [2:0]    op;
    comp_t         comp_0, comp_1, comp_2, comp_3, comp_4, comp_5, comp_6, comp_7, comp_8;
    logic          out_valid;
    logic          out_ready;
    comp_t         res_0, res_1, res_2, res_3, res_4, res_5, res_6, res_7, res_8;

    rotation_scoreboard sb;
    bit                 no_idle;
    int                 quiet_cycles;

    tensor_rotation_3d dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result({res_8, res_7, res_6, res_5, res_4, res_3, res_2, res_1, res_0});
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout with %0d results owed", $time, sb.owed.size());
            $display("** tensor_rotation_3d: FAILED **");
            $finish;
        end
    end

    // receiver with random stalls per item
    initial
    begin
        int idle;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            idle = no_idle ? 0 : $urandom_range(0, 8);
            if (idle > 0)
            begin
                out_ready <= 1'b0;
                repeat (idle) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    function automatic comp_t draw_comp();
        case ($urandom_range(0, 4))
            0: return comp_t'($urandom);
            1: return comp_t'($signed(16'($urandom)));
            2: return comp_t'($signed(8'($urandom)));
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return comp_t'($signed(24'($urandom)));
        endcase
    endfunction

    function automatic axis_t draw_axis();
        case ($urandom_range(0, 5))
            0: return UNIT;
            1: return -UNIT;
            2: return '0;
            default: return axis_t'($urandom_range(0, 2 * UNIT)) - UNIT;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [AW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_axis(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_axes(axis_t a0, axis_t a1, axis_t a2, axis_t b0, axis_t b1, axis_t b2);
        write_reg(REG_ONE_X, a0);
        write_reg(REG_ONE_Y, a1);
        write_reg(REG_ONE_Z, a2);
        write_reg(REG_TWO_X, b0);
        write_reg(REG_TWO_Y, b1);
        write_reg(REG_TWO_Z, b2);
    endtask

    // one item on the input channel; the caller sits just past a falling edge
    task automatic send_tensor(logic [2:0] opc, tensor_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= opc;
        comp_0 <= c[0]; comp_1 <= c[1]; comp_2 <= c[2];
        comp_3 <= c[3]; comp_4 <= c[4]; comp_5 <= c[5];
        comp_6 <= c[6]; comp_7 <= c[7]; comp_8 <= c[8];
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_tensor(opc, c);
        @(negedge clk);
    endtask

    // the caller sits just past a falling edge
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic directed_set();
        tensor_t c;
        for (int k = 0; k < 12; k++)
        begin
            for (int n = 0; n < 9; n++)
            begin
                case (k % 4)
                    0: c[n] = 32'h7fff_ffff;
                    1: c[n] = 32'h8000_0000;
                    2: c[n] = (n % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
                    default: c[n] = comp_t'(n) - 4;
                endcase
            end
            send_tensor(3'(k % 8), c);
        end
        drain();
    endtask

    task automatic random_set(int count);
        tensor_t    c;
        logic [2:0] opc;
        for (int k = 0; k < count; k++)
        begin
            for (int n = 0; n < 9; n++)
            begin
                c[n] = draw_comp();
            end
            opc = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                               : 3'($urandom_range(OP_STRAIN_FWD, OP_GRAD_BCK));
            send_tensor(opc, c);
        end
        drain();
    endtask

    // stimulus
    initial
    begin
        sb = new();
        no_idle = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = '0;
        {comp_0, comp_1, comp_2, comp_3, comp_4, comp_5, comp_6, comp_7, comp_8} = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset axes, then a quarter turn about z
        directed_set();
        load_axes('0, UNIT, '0, -UNIT, '0, '0);
        directed_set();

        // writes past the last register must leave the axes alone
        write_reg(REG_SPARE_LO, 32'hdead_beef);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        random_set(150);

        // extreme axes
        load_axes(UNIT, UNIT, UNIT, UNIT, UNIT, UNIT);
        random_set(150);
        load_axes(-UNIT, -UNIT, -UNIT, -UNIT, UNIT, -UNIT);
        random_set(150);
        load_axes('0, '0, '0, '0, '0, '0);
        random_set(100);

        // random axes, some phases with no idling on either side
        for (int ph = 0; ph < 8; ph++)
        begin
            load_axes(draw_axis(), draw_axis(), draw_axis(),
                      draw_axis(), draw_axis(), draw_axis());
            no_idle = (ph % 3 == 1);
            random_set(140);
        end
        no_idle = 1'b0;

        if (sb.errors == 0 && sb.owed.size() == 0)
        begin
            $display("** tensor_rotation_3d: PASSED **");
        end
        else
        begin
            $display("** tensor_rotation_3d: FAILED **");
        end
        $finish;
    end

endmodule

// ----- tensor_rotation_3d.f -----
sv/trot_pkg.sv
sv/trot_cross.sv
sv/trot_lane.sv
sv/tensor_rotation_3d.sv
sv/trot_checker.sv
tb/sv/tensor_rotation_3d_tb.sv
